FILE: design/assert_macros.svh
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/ufp_pkg.sv
package ufp_pkg;

   localparam logic [7:0] FIXED_PART_BYTES = 8'd10;
   localparam logic [7:0] HEADER_RESET     = 8'hAA;

   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   typedef struct packed {
      logic [7:0] frame_length;
      logic [7:0] device_kind;
      logic [7:0] header_check;
      logic [7:0] message_id;
      logic [7:0] frame_version;
      logic [7:0] device_version;
      logic [7:0] message_kind;
   } ufp_fields_type;

   typedef struct packed {
      logic           result_kind;
      logic [7:0]     payload_byte;
      logic [7:0]     payload_index;
      logic           checksum_ok;
      ufp_fields_type fields;
   } ufp_result_type;

   // parser -> output register
   typedef struct packed {
      logic           load;
      ufp_result_type data;
   } ufp_load_type;

endpackage

FILE: design/ufp_parse.sv
`include "assert_macros.svh"

module ufp_parse
   import ufp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_rx_byte,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data,
   input  logic         room,
   output ufp_load_type load
);

   localparam logic [3:0] PH_HUNT  = 4'd0;
   localparam logic [3:0] PH_LEN   = 4'd1;
   localparam logic [3:0] PH_DEV   = 4'd2;
   localparam logic [3:0] PH_HCHK  = 4'd3;
   localparam logic [3:0] PH_RES1  = 4'd4;
   localparam logic [3:0] PH_RES2  = 4'd5;
   localparam logic [3:0] PH_MID   = 4'd6;
   localparam logic [3:0] PH_FVER  = 4'd7;
   localparam logic [3:0] PH_DVER  = 4'd8;
   localparam logic [3:0] PH_MTYPE = 4'd9;
   localparam logic [3:0] PH_TEXT  = 4'd10;
   localparam logic [3:0] PH_CSUM  = 4'd11;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff, in_byte_in;
   logic [7:0]     hdr_byte_ff, hdr_byte_in;
   logic [3:0]     phase_ff, phase_in;
   logic [7:0]     sum_ff, sum_in;
   logic [7:0]     count_ff, count_in;
   ufp_fields_type fields_ff, fields_in;

   logic           accept;
   logic           advance;
   logic [7:0]     b;
   logic [7:0]     sum_plus;
   logic [7:0]     payload_len;
   logic [7:0]     count_next;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign in_byte_in  = accept ? req_rx_byte : in_byte_ff;
   assign hdr_byte_in = csr_wr_en ? csr_wr_data : hdr_byte_ff;

   assign b           = in_byte_ff;
   assign sum_plus    = sum_ff + b;
   assign payload_len = fields_ff.frame_length - FIXED_PART_BYTES;
   assign count_next  = count_ff + 8'd1;

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      fields_in = fields_ff;

      load.load               = 1'b0;
      load.data.result_kind   = KIND_PAYLOAD;
      load.data.payload_byte  = 8'd0;
      load.data.payload_index = 8'd0;
      load.data.checksum_ok   = 1'b0;
      load.data.fields        = fields_ff;

      if (advance) begin
         unique case (phase_ff)
            PH_HUNT: begin
               sum_in   = 8'd0;
               count_in = 8'd0;
               if (b == hdr_byte_ff) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               fields_in.frame_length = b;
               sum_in   = sum_plus;
               // short length drops the frame
               phase_in = (b < FIXED_PART_BYTES) ? PH_HUNT : PH_DEV;
            end
            PH_DEV: begin
               fields_in.device_kind = b;
               sum_in   = sum_plus;
               phase_in = PH_HCHK;
            end
            PH_HCHK: begin
               fields_in.header_check = b;
               sum_in   = sum_plus;
               phase_in = PH_RES1;
            end
            PH_RES1: begin
               sum_in   = sum_plus;
               phase_in = PH_RES2;
            end
            PH_RES2: begin
               sum_in   = sum_plus;
               phase_in = PH_MID;
            end
            PH_MID: begin
               fields_in.message_id = b;
               sum_in   = sum_plus;
               phase_in = PH_FVER;
            end
            PH_FVER: begin
               fields_in.frame_version = b;
               sum_in   = sum_plus;
               phase_in = PH_DVER;
            end
            PH_DVER: begin
               fields_in.device_version = b;
               sum_in   = sum_plus;
               phase_in = PH_MTYPE;
            end
            PH_MTYPE: begin
               fields_in.message_kind = b;
               sum_in   = sum_plus;
               phase_in = (payload_len != 8'd0) ? PH_TEXT : PH_CSUM;
            end
            PH_TEXT: begin
               load.load               = 1'b1;
               load.data.result_kind   = KIND_PAYLOAD;
               load.data.payload_byte  = b;
               load.data.payload_index = count_ff;
               sum_in   = sum_plus;
               count_in = count_next;
               if (count_next == payload_len) begin
                  phase_in = PH_CSUM;
               end
            end
            PH_CSUM: begin
               load.load             = 1'b1;
               load.data.result_kind = KIND_FRAME_END;
               load.data.checksum_ok = (b == 8'(8'd0 - sum_ff));
               phase_in = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         hdr_byte_ff <= HEADER_RESET;
         phase_ff    <= PH_HUNT;
         sum_ff      <= 8'd0;
         count_ff    <= 8'd0;
         fields_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         hdr_byte_ff <= hdr_byte_in;
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         fields_ff   <= fields_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   `ASSERT_CLK(a_phase_range, clock, reset, phase_ff <= PH_CSUM, "parse phase out of range")
   `ASSERT_CLK(a_text_count, clock, reset, (phase_ff != PH_TEXT) || (count_ff < payload_len), "payload count past payload length")
   `ASSERT_NEXT(a_csum_to_hunt, clock, reset, advance && (phase_ff == PH_CSUM), phase_ff == PH_HUNT, "checksum word did not end the frame")

endmodule

FILE: design/ufp_out_reg.sv
`include "assert_macros.svh"

module ufp_out_reg
   import ufp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  ufp_load_type   load,
   output logic           room,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output ufp_result_type rsp_data
);

   logic           valid_ff, valid_in;
   ufp_result_type data_ff, data_in;

   assign room     = !valid_ff || !rsp_stall;
   assign valid_in = load.load ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);
   assign data_in  = load.load ? load.data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   `ASSERT_CLK(a_load_needs_room, clock, reset, !load.load || room, "result word overwritten while held")

endmodule

FILE: design/uart_frame_parser_top.sv
// Byte-serial frame parser: one received byte per input word, one word per cycle sustained while
// rsp_stall is low. Each byte is registered, runs through the phase decoder and 8-bit checksum
// adder, and any result lands in the output register that drives rsp_valid. Frame layout after
// the header byte: length, device type, header check, two reserved bytes, message id, frame
// version, device version, message type, (length - 10) payload bytes, checksum. Each payload
// byte gives a provisional result; the checksum byte gives a frame-end result with checksum_ok,
// and on checksum_ok = 0 the payload already delivered must be discarded. A length below 10
// drops the frame silently. The checksum must equal the two's complement of the 8-bit sum of
// all bytes after the header.
// csr_wr_data sets the header byte (0xAA after reset); write it only while the block is idle.
module uart_frame_parser_top
   import ufp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic [7:0] rsp_payload_index,
   output logic       rsp_checksum_ok,
   output logic [7:0] rsp_frame_length,
   output logic [7:0] rsp_device_kind,
   output logic [7:0] rsp_header_check,
   output logic [7:0] rsp_message_id,
   output logic [7:0] rsp_frame_version,
   output logic [7:0] rsp_device_version,
   output logic [7:0] rsp_message_kind,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic           room;
   ufp_load_type   load;
   ufp_result_type rsp_data;

   ufp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .room        (room),
      .load        (load)
   );

   ufp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_result_kind    = rsp_data.result_kind;
   assign rsp_payload_byte   = rsp_data.payload_byte;
   assign rsp_payload_index  = rsp_data.payload_index;
   assign rsp_checksum_ok    = rsp_data.checksum_ok;
   assign rsp_frame_length   = rsp_data.fields.frame_length;
   assign rsp_device_kind    = rsp_data.fields.device_kind;
   assign rsp_header_check   = rsp_data.fields.header_check;
   assign rsp_message_id     = rsp_data.fields.message_id;
   assign rsp_frame_version  = rsp_data.fields.frame_version;
   assign rsp_device_version = rsp_data.fields.device_version;
   assign rsp_message_kind   = rsp_data.fields.message_kind;

endmodule

FILE: tb/tb_top.sv
module tb_top;
   import ufp_pkg::*;

   localparam int FIELD_BYTES = 8;  // dev, hchk, two reserved, mid, fver, dver, mtype

   typedef enum logic [3:0] {
      ST_SEEK, ST_LEN, ST_DEV, ST_HCHK, ST_RSV0, ST_RSV1,
      ST_MID, ST_FVER, ST_DVER, ST_MTYPE, ST_BODY, ST_CSUM
   } parse_step_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_payload_index;
   logic       rsp_checksum_ok;
   logic [7:0] rsp_frame_length;
   logic [7:0] rsp_device_kind;
   logic [7:0] rsp_header_check;
   logic [7:0] rsp_message_id;
   logic [7:0] rsp_frame_version;
   logic [7:0] rsp_device_version;
   logic [7:0] rsp_message_kind;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   uart_frame_parser_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_checksum_ok    (rsp_checksum_ok),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_device_kind    (rsp_device_kind),
      .rsp_header_check   (rsp_header_check),
      .rsp_message_id     (rsp_message_id),
      .rsp_frame_version  (rsp_frame_version),
      .rsp_device_version (rsp_device_version),
      .rsp_message_kind   (rsp_message_kind),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // parser shadow
   parse_step_type parser_step = ST_SEEK;
   logic [7:0]     byte_sum = 8'd0;
   logic [7:0]     body_seen = 8'd0;
   logic [7:0]     start_byte = HEADER_RESET;
   ufp_fields_type frame_fields = '0;

   ufp_result_type frame_results_due[$];
   ufp_result_type due_word;
   logic [7:0]     rx_bytes_pending[$];
   int             bytes_queued = 0;
   int             mismatches = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   logic           long_hold = 1'b0;
   logic           pressure_go = 1'b0;

   function automatic void advance_parser(input logic [7:0] b);
      ufp_result_type r;
      logic [7:0]     want;
      r = '0;
      case (parser_step)
         ST_SEEK: begin
            byte_sum  = 8'd0;
            body_seen = 8'd0;
            if (b == start_byte) parser_step = ST_LEN;
         end
         ST_LEN: begin
            frame_fields.frame_length = b;
            byte_sum = byte_sum + b;
            parser_step = (b < FIXED_PART_BYTES) ? ST_SEEK : ST_DEV;
         end
         ST_DEV: begin
            frame_fields.device_kind = b;
            byte_sum = byte_sum + b;
            parser_step = ST_HCHK;
         end
         ST_HCHK: begin
            frame_fields.header_check = b;
            byte_sum = byte_sum + b;
            parser_step = ST_RSV0;
         end
         ST_RSV0: begin
            byte_sum = byte_sum + b;
            parser_step = ST_RSV1;
         end
         ST_RSV1: begin
            byte_sum = byte_sum + b;
            parser_step = ST_MID;
         end
         ST_MID: begin
            frame_fields.message_id = b;
            byte_sum = byte_sum + b;
            parser_step = ST_FVER;
         end
         ST_FVER: begin
            frame_fields.frame_version = b;
            byte_sum = byte_sum + b;
            parser_step = ST_DVER;
         end
         ST_DVER: begin
            frame_fields.device_version = b;
            byte_sum = byte_sum + b;
            parser_step = ST_MTYPE;
         end
         ST_MTYPE: begin
            frame_fields.message_kind = b;
            byte_sum = byte_sum + b;
            parser_step = (frame_fields.frame_length != FIXED_PART_BYTES) ? ST_BODY : ST_CSUM;
         end
         ST_BODY: begin
            r.result_kind   = KIND_PAYLOAD;
            r.payload_byte  = b;
            r.payload_index = body_seen;
            r.checksum_ok   = 1'b0;
            r.fields        = frame_fields;
            frame_results_due.push_back(r);
            byte_sum  = byte_sum + b;
            body_seen = body_seen + 8'd1;
            if (body_seen == frame_fields.frame_length - FIXED_PART_BYTES)
               parser_step = ST_CSUM;
         end
         ST_CSUM: begin
            want = 8'd0 - byte_sum;
            r.result_kind = KIND_FRAME_END;
            r.checksum_ok = (b == want);
            r.fields      = frame_fields;
            frame_results_due.push_back(r);
            parser_step = ST_SEEK;
         end
         default: parser_step = ST_SEEK;
      endcase
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) advance_parser(req_rx_byte);
         if (rx_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_bytes_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         if (mismatches < 100)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (frame_results_due.size() == 0) begin
               if (mismatches < 100)
                  $display("%0t: unexpected result word, expected none, actual kind %0d",
                           $time, rsp_result_kind);
               mismatches++;
            end else begin
               due_word = frame_results_due.pop_front();
               check_field("result_kind", 8'(due_word.result_kind), 8'(rsp_result_kind));
               check_field("payload_byte", due_word.payload_byte, rsp_payload_byte);
               check_field("payload_index", due_word.payload_index, rsp_payload_index);
               check_field("checksum_ok", 8'(due_word.checksum_ok), 8'(rsp_checksum_ok));
               check_field("frame_length", due_word.fields.frame_length, rsp_frame_length);
               check_field("device_kind", due_word.fields.device_kind, rsp_device_kind);
               check_field("header_check", due_word.fields.header_check, rsp_header_check);
               check_field("message_id", due_word.fields.message_id, rsp_message_id);
               check_field("frame_version", due_word.fields.frame_version, rsp_frame_version);
               check_field("device_version", due_word.fields.device_version,
                           rsp_device_version);
               check_field("message_kind", due_word.fields.message_kind, rsp_message_kind);
            end
         end
      end
   end

   // long receiver hold-off so the parser backs up into its input
   initial begin
      while (!pressure_go) @(posedge clock);
      long_hold <= 1'b1;
      repeat (400) @(posedge clock);
      long_hold <= 1'b0;
   end

   function automatic void queue_byte(input logic [7:0] b);
      rx_bytes_pending.push_back(b);
      bytes_queued++;
   endfunction

   // fill < 0 gives random content; cut drops that many trailing bytes
   function automatic void queue_frame(input logic [7:0] hdr, input logic [7:0] len,
                                       input int fill, input bit corrupt, input int cut);
      logic [7:0] frame[$];
      logic [7:0] sum;
      logic [7:0] b;
      frame = {hdr, len};
      sum = len;
      if (len >= FIXED_PART_BYTES) begin
         for (int i = 0; i < int'(len) - int'(FIXED_PART_BYTES) + FIELD_BYTES; i++) begin
            b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            frame.push_back(b);
            sum = sum + b;
         end
         b = 8'd0 - sum;
         if (corrupt) b = b ^ 8'($urandom_range(1, 255));
         frame.push_back(b);
      end
      foreach (frame[k])
         if (k < int'(frame.size()) - cut) queue_byte(frame[k]);
   endfunction

   task automatic queue_random(input int target);
      int         stop_at;
      int         pick;
      logic [7:0] len;
      stop_at = bytes_queued + target;
      while (bytes_queued < stop_at) begin
         if ($urandom_range(9) < 3)
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(255)));
         pick = $urandom_range(99);
         if (pick < 8)
            len = 8'($urandom_range(int'(FIXED_PART_BYTES) - 1));
         else if (pick < 10)
            len = 8'($urandom_range(120, 255));
         else
            len = FIXED_PART_BYTES + 8'($urandom_range(12));
         queue_frame(start_byte, len, -1, $urandom_range(4) == 0,
                     ($urandom_range(19) == 0) ? $urandom_range(1, 4) : 0);
      end
   endtask

   // wait for all words out and the parser back to hunting
   task automatic settle();
      do begin
         while (rx_bytes_pending.size() != 0 || req_valid || frame_results_due.size() != 0)
            @(posedge clock);
         repeat (8) @(posedge clock);
         if (parser_step != ST_SEEK) rx_bytes_pending.push_back(~start_byte);
      end while (parser_step != ST_SEEK);
   endtask

   task automatic write_header(input logic [7:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      start_byte = value;
   endtask

   initial begin
      while (reset) @(posedge clock);

      // noise while hunting, short lengths, empty payload, all-ones with bad checksum
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_frame(start_byte, 8'd0, -1, 1'b0, 0);
      queue_frame(start_byte, FIXED_PART_BYTES - 8'd1, -1, 1'b0, 0);
      queue_frame(start_byte, FIXED_PART_BYTES, 8'h00, 1'b0, 0);
      queue_frame(start_byte, FIXED_PART_BYTES + 8'd1, 8'hFF, 1'b1, 0);
      settle();
      queue_random(350);
      settle();

      write_header(8'h00);
      send_idle_pct = 49;
      queue_random(350);
      settle();

      write_header(8'hFF);
      send_idle_pct  = 0;
      recv_stall_pct = 49;
      queue_random(350);
      settle();

      write_header(8'($urandom_range(1, 254)));
      send_idle_pct  = 25;
      recv_stall_pct = 25;
      queue_random(350);
      settle();

      write_header(HEADER_RESET);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_frame(start_byte, 8'd255, -1, 1'b0, 0);
      queue_random(60);
      pressure_go <= 1'b1;
      settle();

      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("uart_frame_parser_top test passed");
      else
         $display("uart_frame_parser_top test failed");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("uart_frame_parser_top test failed");
      $finish;
   end

endmodule

FILE: uart_frame_parser_top.f
+incdir+design
design/ufp_pkg.sv
design/ufp_parse.sv
design/ufp_out_reg.sv
design/uart_frame_parser_top.sv
tb/tb_top.sv
